### hw/rtl/mesi_pkg.sv
// mesi_pkg: geometry constants, MESI / bus / function codes and index helper
// for the MESI snooping cache controller. No dependencies.
package mesi_pkg;

    localparam int SET_BITS    = 6;
    localparam int WAYS        = 4;
    localparam int OFFSET_BITS = 6;
    localparam int ADDR_BITS   = 32;

    localparam int NSETS      = 1 << SET_BITS;
    localparam int NLINES     = NSETS * WAYS;
    localparam int TAG_BITS   = ADDR_BITS - SET_BITS - OFFSET_BITS;
    localparam int SET_W      = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int WAY_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LINE_BITS  = (NLINES > 1) ? $clog2(NLINES) : 1;
    localparam int STAMP_BITS = 32;

    typedef enum logic [1:0] {
        FN_LOAD   = 2'd0,
        FN_STORE  = 2'd1,
        FN_BUSRD  = 2'd2,
        FN_BUSRDX = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        MESI_I = 2'd0,
        MESI_S = 2'd1,
        MESI_E = 2'd2,
        MESI_M = 2'd3
    } mesi_t;

    typedef enum logic [1:0] {
        BUS_NONE  = 2'd0,
        BUS_RD    = 2'd1,
        BUS_RDX   = 2'd2,
        BUS_RSVD  = 2'd3
    } bus_t;

    // flat line index of one way of one set
    function automatic logic [LINE_BITS-1:0] line_index(input logic [SET_W-1:0] set_i,
                                                        input logic [WAY_BITS-1:0] way_i);
        return LINE_BITS'(int'(set_i) * WAYS + int'(way_i));
    endfunction

endpackage

### hw/rtl/mesi_snooping_cache_controller_unit.sv
// Top level of the MESI snooping cache controller: tag / state / LRU store
// with a way-serial lookup sequencer. Depends on mesi_pkg.
//
//  channel  handshake            payload
//  -------  -------------------  ---------------------------------------------
//  in       in_valid / in_stall  func, address, others_shared, time_stamp
//  out      out_valid/out_stall  access_hit, access_miss, evicted, evicted_tag,
//                                bus_request, memory_fill, flush, invalidated,
//                                snoop_shared, line_state
//
// A word is handled in steps: accept, then one tag/LRU memory read and one
// compare per way through the shared compare unit, then update and result
// write, which waits while an earlier result is still held by out_stall.
// Reset clears the per-line valid bits at once; tag, state and LRU memories
// need no clearing pass. A new word is taken while a result still waits;
// the next result waits in its final step until out_stall drops.
module mesi_snooping_cache_controller_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     func,
    input  logic [31:0]                    address,
    input  logic                           others_shared,
    input  logic [31:0]                    time_stamp,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           access_hit,
    output logic                           access_miss,
    output logic                           evicted,
    output logic [mesi_pkg::TAG_BITS-1:0]  evicted_tag,
    output logic [1:0]                     bus_request,
    output logic                           memory_fill,
    output logic                           flush,
    output logic                           invalidated,
    output logic                           snoop_shared,
    output logic [1:0]                     line_state
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } state_t;

    localparam int TB = mesi_pkg::TAG_BITS;
    localparam int WB = mesi_pkg::WAY_BITS;
    localparam int LB = mesi_pkg::LINE_BITS;
    localparam int SB = mesi_pkg::STAMP_BITS;

    // memories and valid bits
    logic [TB-1:0]              tag_mem  [mesi_pkg::NLINES];
    logic [SB-1:0]              lru_mem  [mesi_pkg::NLINES];
    mesi_pkg::mesi_t            mesi_mem [mesi_pkg::NLINES];
    logic [mesi_pkg::NLINES-1:0] line_valid_reg;

    logic [TB-1:0]              tag_rd_reg;
    logic [SB-1:0]              lru_rd_reg;
    mesi_pkg::mesi_t            mesi_rd_reg;

    // sequencer state
    state_t                     state_reg, state_next;
    mesi_pkg::func_t            func_reg, func_next;
    logic [mesi_pkg::SET_W-1:0] set_reg, set_next;
    logic [TB-1:0]              tag_reg, tag_next;
    logic                       shared_reg, shared_next;
    logic [SB-1:0]              stamp_reg, stamp_next;
    logic [WB-1:0]              way_reg, way_next;

    logic                       found_reg, found_next;
    logic [WB-1:0]              found_way_reg, found_way_next;
    mesi_pkg::mesi_t            found_mesi_reg, found_mesi_next;
    logic                       empty_reg, empty_next;
    logic [WB-1:0]              empty_way_reg, empty_way_next;
    logic [WB-1:0]              best_way_reg, best_way_next;
    logic [SB-1:0]              best_lru_reg, best_lru_next;
    logic [TB-1:0]              best_tag_reg, best_tag_next;

    // result register
    logic                       out_valid_reg, out_valid_next;
    logic                       hit_reg, hit_next;
    logic                       miss_reg, miss_next;
    logic                       evicted_reg, evicted_next;
    logic [TB-1:0]              evicted_tag_reg, evicted_tag_next;
    mesi_pkg::bus_t             bus_reg, bus_next;
    logic                       fill_reg, fill_next;
    logic                       flush_reg, flush_next;
    logic                       inval_reg, inval_next;
    logic                       sshared_reg, sshared_next;
    mesi_pkg::mesi_t            lstate_reg, lstate_next;

    // memory write controls
    logic                       mesi_we, line_we;
    logic [LB-1:0]              wr_idx;
    mesi_pkg::mesi_t            wr_mesi;
    logic [LB-1:0]              rd_idx;

    logic                       rd_valid;
    logic [WB-1:0]              vic_way;
    logic [WB-1:0]              acc_way;
    mesi_pkg::mesi_t            cur_st;
    mesi_pkg::mesi_t            new_st;

    assign rd_idx   = mesi_pkg::line_index(set_reg, way_reg);
    assign rd_valid = line_valid_reg[rd_idx];
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        set_next         = set_reg;
        tag_next         = tag_reg;
        shared_next      = shared_reg;
        stamp_next       = stamp_reg;
        way_next         = way_reg;
        found_next       = found_reg;
        found_way_next   = found_way_reg;
        found_mesi_next  = found_mesi_reg;
        empty_next       = empty_reg;
        empty_way_next   = empty_way_reg;
        best_way_next    = best_way_reg;
        best_lru_next    = best_lru_reg;
        best_tag_next    = best_tag_reg;
        out_valid_next   = out_valid_reg;
        hit_next         = hit_reg;
        miss_next        = miss_reg;
        evicted_next     = evicted_reg;
        evicted_tag_next = evicted_tag_reg;
        bus_next         = bus_reg;
        fill_next        = fill_reg;
        flush_next       = flush_reg;
        inval_next       = inval_reg;
        sshared_next     = sshared_reg;
        lstate_next      = lstate_reg;
        mesi_we          = 1'b0;
        line_we          = 1'b0;
        wr_idx           = mesi_pkg::line_index(set_reg, found_way_reg);
        wr_mesi          = mesi_pkg::MESI_I;
        vic_way          = empty_reg ? empty_way_reg : best_way_reg;
        acc_way          = found_reg ? found_way_reg : vic_way;
        cur_st           = found_reg ? found_mesi_reg : mesi_pkg::MESI_I;
        new_st           = cur_st;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next   = mesi_pkg::func_t'(func);
                    set_next    = mesi_pkg::SET_W'(address >> mesi_pkg::OFFSET_BITS);
                    tag_next    = TB'(address >> (mesi_pkg::SET_BITS + mesi_pkg::OFFSET_BITS));
                    shared_next = others_shared;
                    stamp_next  = time_stamp;
                    way_next    = '0;
                    found_next  = 1'b0;
                    empty_next  = 1'b0;
                    state_next  = ST_READ;
                end
            end

            ST_READ:
            begin
                state_next = ST_CMP;
            end

            ST_CMP:
            begin
                // one way through the shared tag / LRU comparator
                if (rd_valid && tag_rd_reg == tag_reg && !found_reg)
                begin
                    found_next      = 1'b1;
                    found_way_next  = way_reg;
                    found_mesi_next = mesi_rd_reg;
                end
                if (!rd_valid && !empty_reg)
                begin
                    empty_next     = 1'b1;
                    empty_way_next = way_reg;
                end
                if (way_reg == '0 || lru_rd_reg < best_lru_reg)
                begin
                    best_way_next = way_reg;
                    best_lru_next = lru_rd_reg;
                    best_tag_next = tag_rd_reg;
                end
                if (way_reg == WB'(mesi_pkg::WAYS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    way_next   = way_reg + WB'(1);
                    state_next = ST_READ;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    hit_next         = 1'b0;
                    miss_next        = 1'b0;
                    evicted_next     = 1'b0;
                    evicted_tag_next = '0;
                    bus_next         = mesi_pkg::BUS_NONE;
                    fill_next        = 1'b0;
                    flush_next       = 1'b0;
                    inval_next       = 1'b0;
                    sshared_next     = 1'b0;
                    lstate_next      = mesi_pkg::MESI_I;
                    state_next       = ST_IDLE;

                    if (func_reg inside {mesi_pkg::FN_BUSRD, mesi_pkg::FN_BUSRDX})
                    begin
                        if (found_reg)
                        begin
                            flush_next   = (cur_st == mesi_pkg::MESI_M);
                            sshared_next = (cur_st != mesi_pkg::MESI_I);
                            if (func_reg == mesi_pkg::FN_BUSRD)
                            begin
                                new_st = (cur_st != mesi_pkg::MESI_I) ? mesi_pkg::MESI_S
                                                                     : mesi_pkg::MESI_I;
                            end
                            else
                            begin
                                inval_next = (cur_st != mesi_pkg::MESI_I);
                                new_st     = mesi_pkg::MESI_I;
                            end
                            mesi_we     = 1'b1;
                            wr_mesi     = new_st;
                            lstate_next = new_st;
                        end
                    end
                    else
                    begin
                        if (found_reg)
                        begin
                            hit_next  = (cur_st != mesi_pkg::MESI_I);
                            miss_next = (cur_st == mesi_pkg::MESI_I);
                        end
                        else
                        begin
                            miss_next = 1'b1;
                            // no empty way: replace the LRU line
                            if (!empty_reg)
                            begin
                                evicted_next     = 1'b1;
                                evicted_tag_next = best_tag_reg;
                            end
                        end
                        if (func_reg == mesi_pkg::FN_LOAD)
                        begin
                            if (cur_st == mesi_pkg::MESI_I)
                            begin
                                bus_next  = mesi_pkg::BUS_RD;
                                fill_next = !shared_reg;
                                new_st    = shared_reg ? mesi_pkg::MESI_S : mesi_pkg::MESI_E;
                            end
                        end
                        else
                        begin
                            if (cur_st inside {mesi_pkg::MESI_I, mesi_pkg::MESI_S})
                            begin
                                bus_next  = mesi_pkg::BUS_RDX;
                                fill_next = (cur_st == mesi_pkg::MESI_I) && !shared_reg;
                            end
                            new_st = mesi_pkg::MESI_M;
                        end
                        wr_idx      = mesi_pkg::line_index(set_reg, acc_way);
                        mesi_we     = 1'b1;
                        line_we     = 1'b1;
                        wr_mesi     = new_st;
                        lstate_next = new_st;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            func_reg        <= mesi_pkg::FN_LOAD;
            set_reg         <= '0;
            tag_reg         <= '0;
            shared_reg      <= 1'b0;
            stamp_reg       <= '0;
            way_reg         <= '0;
            found_reg       <= 1'b0;
            found_way_reg   <= '0;
            found_mesi_reg  <= mesi_pkg::MESI_I;
            empty_reg       <= 1'b0;
            empty_way_reg   <= '0;
            best_way_reg    <= '0;
            best_lru_reg    <= '0;
            best_tag_reg    <= '0;
            out_valid_reg   <= 1'b0;
            hit_reg         <= 1'b0;
            miss_reg        <= 1'b0;
            evicted_reg     <= 1'b0;
            evicted_tag_reg <= '0;
            bus_reg         <= mesi_pkg::BUS_NONE;
            fill_reg        <= 1'b0;
            flush_reg       <= 1'b0;
            inval_reg       <= 1'b0;
            sshared_reg     <= 1'b0;
            lstate_reg      <= mesi_pkg::MESI_I;
        end
        else
        begin
            state_reg       <= state_next;
            func_reg        <= func_next;
            set_reg         <= set_next;
            tag_reg         <= tag_next;
            shared_reg      <= shared_next;
            stamp_reg       <= stamp_next;
            way_reg         <= way_next;
            found_reg       <= found_next;
            found_way_reg   <= found_way_next;
            found_mesi_reg  <= found_mesi_next;
            empty_reg       <= empty_next;
            empty_way_reg   <= empty_way_next;
            best_way_reg    <= best_way_next;
            best_lru_reg    <= best_lru_next;
            best_tag_reg    <= best_tag_next;
            out_valid_reg   <= out_valid_next;
            hit_reg         <= hit_next;
            miss_reg        <= miss_next;
            evicted_reg     <= evicted_next;
            evicted_tag_reg <= evicted_tag_next;
            bus_reg         <= bus_next;
            fill_reg        <= fill_next;
            flush_reg       <= flush_next;
            inval_reg       <= inval_next;
            sshared_reg     <= sshared_next;
            lstate_reg      <= lstate_next;
        end
    end

    // valid bits: cleared by reset, set on first fill, never cleared again
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_valid_reg <= '0;
        end
        else if (line_we)
        begin
            line_valid_reg[wr_idx] <= 1'b1;
        end
    end

    // tag / LRU / state memories: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            tag_mem[wr_idx] <= tag_reg;
            lru_mem[wr_idx] <= stamp_reg;
        end
        if (mesi_we)
        begin
            mesi_mem[wr_idx] <= wr_mesi;
        end
        tag_rd_reg  <= tag_mem[rd_idx];
        lru_rd_reg  <= lru_mem[rd_idx];
        mesi_rd_reg <= mesi_mem[rd_idx];
    end

    assign out_valid    = out_valid_reg;
    assign access_hit   = hit_reg;
    assign access_miss  = miss_reg;
    assign evicted      = evicted_reg;
    assign evicted_tag  = evicted_tag_reg;
    assign bus_request  = bus_reg;
    assign memory_fill  = fill_reg;
    assign flush        = flush_reg;
    assign invalidated  = inval_reg;
    assign snoop_shared = sshared_reg;
    assign line_state   = lstate_reg;

endmodule

### tb/sv/tb_mesi_snooping_cache_controller_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for mesi_snooping_cache_controller_unit: queue-fed driver, clocked
// monitor and a MESI tag/state/LRU predictor of its own. Depends on mesi_pkg and the unit RTL.
module tb_mesi_snooping_cache_controller_unit;

    localparam int WORD_CYCLES = 2 * mesi_pkg::WAYS + 2;
    localparam int CYCLE_LIMIT = 100000;
    localparam int PHASE_B     = 140;   // words accepted before the idling swaps
    localparam int PHASE_C     = 280;   // words accepted before idling stops
    localparam int HOLD_AT     = 320;   // long receiver hold-off starts here
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_WORDS = 400;

    typedef struct {
        mesi_pkg::func_t fn;
        logic [31:0]     address;
        logic            shared;
        logic [31:0]     stamp;
    } word_t;

    typedef struct {
        logic                          access_hit;
        logic                          access_miss;
        logic                          evicted;
        logic [mesi_pkg::TAG_BITS-1:0] evicted_tag;
        mesi_pkg::bus_t                bus_request;
        logic                          memory_fill;
        logic                          flush;
        logic                          invalidated;
        logic                          snoop_shared;
        mesi_pkg::mesi_t               line_state;
    } outcome_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [1:0]                    func = mesi_pkg::FN_LOAD;
    logic [31:0]                   address = '0;
    logic                          others_shared = 1'b0;
    logic [31:0]                   time_stamp = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic                          access_hit;
    logic                          access_miss;
    logic                          evicted;
    logic [mesi_pkg::TAG_BITS-1:0] evicted_tag;
    logic [1:0]                    bus_request;
    logic                          memory_fill;
    logic                          flush;
    logic                          invalidated;
    logic                          snoop_shared;
    logic [1:0]                    line_state;

    // predictor copy of the cache directory
    logic                          line_ok   [mesi_pkg::NLINES];
    logic [mesi_pkg::TAG_BITS-1:0] line_tag  [mesi_pkg::NLINES];
    mesi_pkg::mesi_t               line_mesi [mesi_pkg::NLINES];
    logic [31:0]                   line_use  [mesi_pkg::NLINES];

    word_t    pending_words[$];
    outcome_t expected_results[$];
    word_t    cur_word;
    int       words_in = 0;
    int       results_seen = 0;
    int       errors = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    int unsigned cycles = 0;
    int       send_idle_pct;
    int       recv_idle_pct;

    mesi_snooping_cache_controller_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .address       (address),
        .others_shared (others_shared),
        .time_stamp    (time_stamp),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .access_hit    (access_hit),
        .access_miss   (access_miss),
        .evicted       (evicted),
        .evicted_tag   (evicted_tag),
        .bus_request   (bus_request),
        .memory_fill   (memory_fill),
        .flush         (flush),
        .invalidated   (invalidated),
        .snoop_shared  (snoop_shared),
        .line_state    (line_state)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one word to the directory and returns the result it must produce.
    function automatic outcome_t coherence_outcome(word_t w);
        outcome_t                      o;
        logic [mesi_pkg::SET_W-1:0]    set_i;
        logic [mesi_pkg::TAG_BITS-1:0] tag_i;
        int                            base;
        int                            hit_way;
        int                            victim;
        int                            idx;
        mesi_pkg::mesi_t               st;
        o.access_hit   = 1'b0;
        o.access_miss  = 1'b0;
        o.evicted      = 1'b0;
        o.evicted_tag  = '0;
        o.bus_request  = mesi_pkg::BUS_NONE;
        o.memory_fill  = 1'b0;
        o.flush        = 1'b0;
        o.invalidated  = 1'b0;
        o.snoop_shared = 1'b0;
        o.line_state   = mesi_pkg::MESI_I;
        set_i   = w.address[mesi_pkg::OFFSET_BITS +: mesi_pkg::SET_BITS];
        tag_i   = w.address[mesi_pkg::ADDR_BITS-1 -: mesi_pkg::TAG_BITS];
        base    = int'(set_i) * mesi_pkg::WAYS;
        hit_way = -1;
        for (int k = 0; k < mesi_pkg::WAYS; k++)
            if (hit_way < 0 && line_ok[base + k] && line_tag[base + k] == tag_i)
                hit_way = k;

        if (w.fn inside {mesi_pkg::FN_BUSRD, mesi_pkg::FN_BUSRDX})
        begin
            // a snoop that misses leaves everything untouched
            if (hit_way >= 0)
            begin
                idx = base + hit_way;
                st  = line_mesi[idx];
                o.flush        = (st == mesi_pkg::MESI_M);
                o.snoop_shared = (st != mesi_pkg::MESI_I);
                if (w.fn == mesi_pkg::FN_BUSRD)
                begin
                    if (st != mesi_pkg::MESI_I)
                        line_mesi[idx] = mesi_pkg::MESI_S;
                end
                else
                begin
                    o.invalidated  = (st != mesi_pkg::MESI_I);
                    line_mesi[idx] = mesi_pkg::MESI_I;
                end
                o.line_state = line_mesi[idx];
            end
            return o;
        end

        if (hit_way >= 0)
        begin
            idx = base + hit_way;
            if (line_mesi[idx] != mesi_pkg::MESI_I)
                o.access_hit = 1'b1;
            else
                o.access_miss = 1'b1;   // coherence miss, line reused in place
        end
        else
        begin
            o.access_miss = 1'b1;
            victim = -1;
            for (int k = 0; k < mesi_pkg::WAYS; k++)
                if (victim < 0 && !line_ok[base + k])
                    victim = k;
            if (victim < 0)
            begin
                // LRU: lowest stamp, ties to the lowest way
                victim = 0;
                for (int k = 1; k < mesi_pkg::WAYS; k++)
                    if (line_use[base + k] < line_use[base + victim])
                        victim = k;
            end
            idx = base + victim;
            if (line_ok[idx])
            begin
                o.evicted      = 1'b1;
                o.evicted_tag  = line_tag[idx];
                line_mesi[idx] = mesi_pkg::MESI_I;
            end
        end
        line_ok[idx]  = 1'b1;
        line_tag[idx] = tag_i;
        line_use[idx] = w.stamp;
        st = line_mesi[idx];
        if (w.fn == mesi_pkg::FN_LOAD)
        begin
            if (st == mesi_pkg::MESI_I)
            begin
                o.bus_request = mesi_pkg::BUS_RD;
                if (w.shared)
                    line_mesi[idx] = mesi_pkg::MESI_S;
                else
                begin
                    line_mesi[idx] = mesi_pkg::MESI_E;
                    o.memory_fill  = 1'b1;
                end
            end
        end
        else
        begin
            if (st inside {mesi_pkg::MESI_I, mesi_pkg::MESI_S})
            begin
                o.bus_request = mesi_pkg::BUS_RDX;
                o.memory_fill = (st == mesi_pkg::MESI_I) && !w.shared;
            end
            line_mesi[idx] = mesi_pkg::MESI_M;
        end
        o.line_state = line_mesi[idx];
        return o;
    endfunction

    function automatic logic [31:0] line_addr(int t, int s, int off);
        return {mesi_pkg::TAG_BITS'(t), mesi_pkg::SET_BITS'(s), mesi_pkg::OFFSET_BITS'(off)};
    endfunction

    task automatic add_word(mesi_pkg::func_t f, logic [31:0] a, logic sh, logic [31:0] ts);
        word_t w;
        w.fn      = f;
        w.address = a;
        w.shared  = sh;
        w.stamp   = ts;
        pending_words.push_back(w);
    endtask

    task automatic report_error(string msg);
        errors++;
        $display("%0t ns: word %0d: %s", $time, results_seen, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s is %0h, want %0h", name, got, want));
    endtask

    always_comb
    begin
        send_idle_pct = (words_in < PHASE_B) ? 11 : (words_in < PHASE_C) ? 67 : 0;
        recv_idle_pct = (words_in < PHASE_B) ? 67 : (words_in < PHASE_C) ? 11 : 0;
    end

    // driver: predicts each accepted word, then offers the next one
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_stall === 1'b0)
            begin
                expected_results.push_back(coherence_outcome(cur_word));
                words_in <= words_in + 1;
            end
            if (!(in_valid && in_stall !== 1'b0))
            begin
                if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_word = pending_words.pop_front();
                    in_valid      <= 1'b1;
                    func          <= cur_word.fn;
                    address       <= cur_word.address;
                    others_shared <= cur_word.shared;
                    time_stamp    <= cur_word.stamp;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the unit backs up into its input
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && words_in >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // monitor: checks each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid === 1'b1 && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_error("result with no word outstanding");
                else
                begin
                    outcome_t want;
                    want = expected_results.pop_front();
                    check_field("access_hit", 32'(access_hit), 32'(want.access_hit));
                    check_field("access_miss", 32'(access_miss), 32'(want.access_miss));
                    check_field("evicted", 32'(evicted), 32'(want.evicted));
                    check_field("evicted_tag", 32'(evicted_tag), 32'(want.evicted_tag));
                    check_field("bus_request", 32'(bus_request), 32'(want.bus_request));
                    check_field("memory_fill", 32'(memory_fill), 32'(want.memory_fill));
                    check_field("flush", 32'(flush), 32'(want.flush));
                    check_field("invalidated", 32'(invalidated), 32'(want.invalidated));
                    check_field("snoop_shared", 32'(snoop_shared), 32'(want.snoop_shared));
                    check_field("line_state", 32'(line_state), 32'(want.line_state));
                end
                results_seen <= results_seen + 1;
            end
            out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_mesi_snooping_cache_controller_unit: errors");
            $finish;
        end
    end

    initial
    begin
        logic [mesi_pkg::TAG_BITS-1:0] hot_tag [6];
        logic [mesi_pkg::SET_BITS-1:0] hot_set [4];
        logic [mesi_pkg::TAG_BITS-1:0] t;
        logic [mesi_pkg::SET_BITS-1:0] s;
        logic [31:0]                   stamp;
        logic [31:0]                   ts;
        int                            made;
        int                            burst;
        mesi_pkg::func_t               f;

        for (int i = 0; i < mesi_pkg::NLINES; i++)
        begin
            line_ok[i]   = 1'b0;
            line_tag[i]  = '0;
            line_mesi[i] = mesi_pkg::MESI_I;
            line_use[i]  = '0;
        end

        // directed: walk one line of set 0 through every MESI transition
        add_word(mesi_pkg::FN_LOAD,   line_addr(0, 0, 0), 1'b0, 10);  // miss, fill, E
        add_word(mesi_pkg::FN_LOAD,   line_addr(0, 0, 5), 1'b1, 11);  // hit in E
        add_word(mesi_pkg::FN_STORE,  line_addr(0, 0, 9), 1'b0, 12);  // silent E to M
        add_word(mesi_pkg::FN_BUSRD,  line_addr(0, 0, 0), 1'b0, 0);   // flush, down to S
        add_word(mesi_pkg::FN_BUSRD,  line_addr(0, 0, 0), 1'b0, 0);   // shared, stays S
        add_word(mesi_pkg::FN_STORE,  line_addr(0, 0, 1), 1'b1, 13);  // upgrade, BusRdX
        add_word(mesi_pkg::FN_BUSRDX, line_addr(0, 0, 2), 1'b0, 0);   // flush and invalidate
        add_word(mesi_pkg::FN_BUSRD,  line_addr(0, 0, 0), 1'b1, 0);   // snoop of line in I
        add_word(mesi_pkg::FN_BUSRDX, line_addr(0, 0, 0), 1'b1, 0);   // same, exclusive
        add_word(mesi_pkg::FN_LOAD,   line_addr(0, 0, 3), 1'b1, 14);  // coherence miss, S
        add_word(mesi_pkg::FN_STORE,  line_addr(1, 0, 0), 1'b0, 5);   // empty way, memory fill
        add_word(mesi_pkg::FN_STORE,  line_addr(2, 0, 0), 1'b1, 5);   // empty way, stamp tie
        add_word(mesi_pkg::FN_LOAD,   line_addr(3, 0, 0), 1'b0, 20);  // set 0 now full
        add_word(mesi_pkg::FN_BUSRDX, line_addr(3, 0, 0), 1'b0, 0);   // E invalidated, no flush
        add_word(mesi_pkg::FN_STORE,  line_addr(3, 0, 0), 1'b0, 21);  // store from I
        add_word(mesi_pkg::FN_LOAD,   line_addr(4, 0, 0), 1'b0, 30);  // evicts lowest tied way
        add_word(mesi_pkg::FN_BUSRDX, line_addr(9, 0, 0), 1'b1, 0);   // snoop miss
        add_word(mesi_pkg::FN_BUSRD,  line_addr(9, 0, 0), 1'b1, 0);
        add_word(mesi_pkg::FN_LOAD,   32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        add_word(mesi_pkg::FN_STORE,  32'hFFFF_FFFF, 1'b1, 32'h0);       // S to M via BusRdX
        add_word(mesi_pkg::FN_BUSRD,  32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
        add_word(mesi_pkg::FN_STORE,  line_addr('1, '1, 0), 1'b0, 32'h0);
        add_word(mesi_pkg::FN_STORE,  line_addr('1 - 1, '1, 0), 1'b0, 32'h0);
        add_word(mesi_pkg::FN_STORE,  line_addr('1 - 2, '1, 0), 1'b0, 32'h8000_0000);
        // fills the last empty way of the top set, so no LRU pick
        add_word(mesi_pkg::FN_LOAD,   line_addr(7, '1, 0), 1'b0, 32'h7FFF_FFFF);

        // random: bursts on a few hot lines so hits, snoops and evictions all recur
        foreach (hot_tag[i]) hot_tag[i] = mesi_pkg::TAG_BITS'($urandom);
        foreach (hot_set[i]) hot_set[i] = mesi_pkg::SET_BITS'($urandom);
        stamp = 32'd100;
        made  = 0;
        while (made < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: any address, any function
                add_word(mesi_pkg::func_t'($urandom_range(0, 3)), $urandom, 1'($urandom),
                         $urandom);
                made++;
            end
            else
            begin
                t = hot_tag[$urandom_range(0, 5)];
                s = ($urandom_range(0, 4) == 0) ? mesi_pkg::SET_BITS'($urandom)
                                                : hot_set[$urandom_range(0, 3)];
                burst = $urandom_range(1, 4);
                for (int b = 0; b < burst; b++)
                begin
                    case ($urandom_range(0, 19)) inside
                        [0:6]:   f = mesi_pkg::FN_LOAD;
                        [7:12]:  f = mesi_pkg::FN_STORE;
                        [13:15]: f = mesi_pkg::FN_BUSRD;
                        default: f = mesi_pkg::FN_BUSRDX;
                    endcase
                    stamp = stamp + $urandom_range(0, 3);   // zero steps give LRU ties
                    ts = ($urandom_range(0, 4) == 0) ? $urandom : stamp;
                    add_word(f, line_addr(int'(t), int'(s), int'($urandom)), 1'($urandom), ts);
                    made++;
                end
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4 * WORD_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
            report_error("words with no result at the end of the run");

        if (errors == 0)
            $display("tb_mesi_snooping_cache_controller_unit: clean");
        else
            $display("tb_mesi_snooping_cache_controller_unit: errors");
        $finish;
    end

endmodule

### mesi_snooping_cache_controller_unit.f
hw/rtl/mesi_pkg.sv
hw/rtl/mesi_snooping_cache_controller_unit.sv
tb/sv/tb_mesi_snooping_cache_controller_unit.sv
